// File: hw/rtl/tfla_pkg.sv
package tfla_pkg;

    // Pool geometry
    localparam int MAX_BLOCKS = 1024;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int LINK_W     = IDX_W + 1;
    localparam int CNT_W      = LINK_W;
    localparam int TAG_W      = 8;
    localparam int OP_W       = 2;
    localparam int STAT_W     = 2;

    localparam logic [LINK_W-1:0] NULL_CODE = LINK_W'(MAX_BLOCKS);

    // APB register map
    localparam int APB_AW = 2;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-1:0] REG_POOL_CAPACITY = APB_AW'(0);

    // Opcodes
    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
    localparam logic [OP_W-1:0] OP_REBUILD = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE    = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOT_INIT = 2'd3;

    // Shared arithmetic unit
    typedef logic [1:0] alu_op_t;
    localparam alu_op_t ALU_INC = 2'd0;   // a+1, held at b; flag = a+1 >= b
    localparam alu_op_t ALU_DEC = 2'd1;   // a-1, held at 0; flag = a == 0
    localparam alu_op_t ALU_GE  = 2'd2;   // pass a; flag = a >= b

    typedef struct packed {
        alu_op_t             op;
        logic [LINK_W-1:0]   a;
        logic [LINK_W-1:0]   b;
    } alu_req_t;

    typedef struct packed {
        logic [LINK_W-1:0]   res;
        logic                flag;
    } alu_rsp_t;

endpackage

// File: hw/rtl/tfla_if.sv
interface tfla_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [tfla_pkg::OP_W-1:0]     opcode;
    logic [tfla_pkg::IDX_W-1:0]    block_index;

    modport source (output valid, output opcode, output block_index, input ready);
    modport sink   (input valid, input opcode, input block_index, output ready);
endinterface

interface tfla_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [tfla_pkg::IDX_W-1:0]    granted_index;
    logic [tfla_pkg::STAT_W-1:0]   status;
    logic [tfla_pkg::TAG_W-1:0]    head_tag;
    logic [tfla_pkg::CNT_W-1:0]    free_count;
    logic                          pool_empty;

    modport source (output valid, output granted_index, output status, output head_tag,
                    output free_count, output pool_empty, input ready);
    modport sink   (input valid, input granted_index, input status, input head_tag,
                    input free_count, input pool_empty, output ready);
endinterface

// File: hw/rtl/tagged_free_list_allocator.sv
// Channel  Dir  Handshake      Payload
// -------  ---  -------------  -------------------------------------------------------
// cmd      in   valid/ready    opcode, block_index
// rsp      out  valid/ready    granted_index, status, head_tag, free_count, pool_empty
// apb      in   psel/penable   pool_capacity at byte address 0 (pready tied high)
//
// One command at a time; cmd.ready is high only while the sequencer is idle.
// The sequencer steps each command through the single arithmetic unit (tag,
// counter, compare and link index all go through it one step a cycle) and
// the single-port link RAM. A result sits in the rsp register, so the next
// command is taken while it waits; a stalled rsp only holds the sequencer at
// its last step. Reset clears head, tag, counter and capacity; the link RAM is
// not cleared and needs no clearing pass.
module tagged_free_list_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    tfla_cmd_if.sink                      cmd,
    tfla_rsp_if.source                    rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tfla_pkg::APB_AW-1:0]   paddr,
    input  logic [tfla_pkg::APB_DW-1:0]   pwdata,
    output logic [tfla_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import tfla_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_DISPATCH   = 3'd1;
    localparam logic [2:0] S_ALLOC_LINK = 3'd2;
    localparam logic [2:0] S_TAG        = 3'd3;
    localparam logic [2:0] S_COUNT      = 3'd4;
    localparam logic [2:0] S_BUILD      = 3'd5;
    localparam logic [2:0] S_DONE       = 3'd6;

    logic [2:0]          state_reg,      state_next;
    logic [OP_W-1:0]     op_reg,         op_next;
    logic [IDX_W-1:0]    idx_reg,        idx_next;
    logic [LINK_W-1:0]   head_reg,       head_next;
    logic [TAG_W-1:0]    tag_reg,        tag_next;
    logic [CNT_W-1:0]    count_reg,      count_next;
    logic [CNT_W-1:0]    build_reg,      build_next;
    logic                inc_reg,        inc_next;
    logic [CNT_W-1:0]    cap_reg;
    logic [IDX_W-1:0]    res_granted_reg, res_granted_next;
    logic [STAT_W-1:0]   res_status_reg,  res_status_next;
    logic                out_valid_reg,  out_valid_next;

    logic [IDX_W-1:0]    out_granted_reg;
    logic [STAT_W-1:0]   out_status_reg;
    logic [TAG_W-1:0]    out_tag_reg;
    logic [CNT_W-1:0]    out_count_reg;
    logic                out_empty_reg;

    logic [CNT_W-1:0]    cap_eff;
    logic                cap_zero;
    logic                out_free;
    logic                out_load;
    logic                cfg_wr;

    alu_req_t            alu_req;
    alu_rsp_t            alu_rsp;

    logic                mem_we;
    logic [IDX_W-1:0]    mem_addr;
    logic [LINK_W-1:0]   mem_wdata;
    logic [LINK_W-1:0]   mem_rdata;

    tfla_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    tfla_link_ram u_link_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == REG_POOL_CAPACITY);
    assign prdata = (paddr == REG_POOL_CAPACITY) ? APB_DW'(cap_reg) : '0;

    // capacity above the pool size saturates
    assign cap_eff  = (cap_reg > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : cap_reg;
    assign cap_zero = (cap_eff == '0);

    // ---------------- handshakes ----------------
    assign cmd.ready = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || rsp.ready;

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        idx_next         = idx_reg;
        head_next        = head_reg;
        tag_next         = tag_reg;
        count_next       = count_reg;
        build_next       = build_reg;
        inc_next         = inc_reg;
        res_granted_next = res_granted_reg;
        res_status_next  = res_status_reg;
        out_load         = 1'b0;
        alu_req.op       = ALU_GE;
        alu_req.a        = '0;
        alu_req.b        = '0;
        mem_we           = 1'b0;
        mem_addr         = head_reg[IDX_W-1:0];
        mem_wdata        = head_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    op_next    = cmd.opcode;
                    idx_next   = cmd.block_index;
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                res_granted_next = '0;
                res_status_next  = ST_OK;
                case (op_reg)
                    OP_ALLOC:
                    begin
                        if (cap_zero)
                        begin
                            res_status_next = ST_NOT_INIT;
                            state_next      = S_DONE;
                        end
                        else if (head_reg == NULL_CODE)
                        begin
                            res_status_next = ST_EMPTY;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            // pop: read the head's link, data back next cycle
                            res_granted_next = head_reg[IDX_W-1:0];
                            state_next       = S_ALLOC_LINK;
                        end
                    end
                    OP_FREE:
                    begin
                        alu_req.op = ALU_GE;
                        alu_req.a  = {1'b0, idx_reg};
                        alu_req.b  = cap_eff;
                        if (cap_zero)
                        begin
                            res_status_next = ST_NOT_INIT;
                            state_next      = S_DONE;
                        end
                        else if (alu_rsp.flag)
                        begin
                            res_status_next = ST_RANGE;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            // push: link the block to the old head
                            mem_we     = 1'b1;
                            mem_addr   = idx_reg;
                            mem_wdata  = head_reg;
                            head_next  = {1'b0, idx_reg};
                            inc_next   = 1'b1;
                            state_next = S_TAG;
                        end
                    end
                    OP_REBUILD:
                    begin
                        if (cap_zero)
                        begin
                            res_status_next = ST_NOT_INIT;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            build_next = '0;
                            state_next = S_BUILD;
                        end
                    end
                    default:
                    begin
                        res_status_next = ST_RANGE;
                        state_next      = S_DONE;
                    end
                endcase
            end

            S_ALLOC_LINK:
            begin
                // a link at or above the pool size ends the list
                alu_req.op = ALU_GE;
                alu_req.a  = mem_rdata;
                alu_req.b  = NULL_CODE;
                head_next  = alu_rsp.flag ? NULL_CODE : mem_rdata;
                inc_next   = 1'b0;
                state_next = S_TAG;
            end

            S_TAG:
            begin
                // b all ones: never holds, low byte wraps
                alu_req.op = ALU_INC;
                alu_req.a  = LINK_W'(tag_reg);
                alu_req.b  = '1;
                tag_next   = alu_rsp.res[TAG_W-1:0];
                state_next = S_COUNT;
            end

            S_COUNT:
            begin
                alu_req.op = inc_reg ? ALU_INC : ALU_DEC;
                alu_req.a  = count_reg;
                alu_req.b  = NULL_CODE;
                count_next = alu_rsp.res;
                state_next = S_DONE;
            end

            S_BUILD:
            begin
                // entry i gets i+1, the last one gets the null code
                alu_req.op = ALU_INC;
                alu_req.a  = build_reg;
                alu_req.b  = cap_eff;
                mem_we     = 1'b1;
                mem_addr   = build_reg[IDX_W-1:0];
                mem_wdata  = alu_rsp.flag ? NULL_CODE : alu_rsp.res;
                build_next = alu_rsp.res;
                if (alu_rsp.flag)
                begin
                    head_next  = '0;
                    tag_next   = '0;
                    count_next = cap_eff;
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // ---------------- control and list state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= NULL_CODE;
            tag_reg       <= '0;
            count_reg     <= '0;
            cap_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tag_reg       <= tag_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr)
            begin
                cap_reg <= pwdata[CNT_W-1:0];
            end
        end
    end

    // ---------------- working and result payload ----------------
    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        idx_reg         <= idx_next;
        build_reg       <= build_next;
        inc_reg         <= inc_next;
        res_granted_reg <= res_granted_next;
        res_status_reg  <= res_status_next;
        if (out_load)
        begin
            out_granted_reg <= res_granted_reg;
            out_status_reg  <= res_status_reg;
            out_tag_reg     <= tag_reg;
            out_count_reg   <= count_reg;
            out_empty_reg   <= (head_reg == NULL_CODE);
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.granted_index = out_granted_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.head_tag      = out_tag_reg;
    assign rsp.free_count    = out_count_reg;
    assign rsp.pool_empty    = out_empty_reg;

    // ---------------- checks ----------------
    // head is either a block of the pool or the null code
    assert property (@(posedge clk) disable iff (!rst_n) head_reg <= NULL_CODE)
        else $error("list head beyond null code");

    // counter never passes the pool size
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_W'(MAX_BLOCKS))
        else $error("free counter beyond pool size");

    // rebuild walks only inside the effective capacity
    assert property (@(posedge clk) disable iff (!rst_n)
                     (state_reg == S_BUILD) |-> (build_reg < cap_eff))
        else $error("rebuild index beyond capacity");

    // an accepted command is dispatched on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
                     (cmd.valid && cmd.ready) |=> (state_reg == S_DISPATCH))
        else $error("accepted command not dispatched");

endmodule

// File: hw/rtl/tfla_link_ram.sv
module tfla_link_ram (
    input  logic                          clk,
    input  logic                          we,
    input  logic [tfla_pkg::IDX_W-1:0]    addr,
    input  logic [tfla_pkg::LINK_W-1:0]   wdata,
    output logic [tfla_pkg::LINK_W-1:0]   rdata
);
    import tfla_pkg::*;

    logic [LINK_W-1:0] mem [MAX_BLOCKS];
    logic [LINK_W-1:0] rdata_reg;

    // single port, registered read (old data on a write)
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/tfla_alu.sv
module tfla_alu (
    input  tfla_pkg::alu_req_t req,
    output tfla_pkg::alu_rsp_t rsp
);
    import tfla_pkg::*;

    logic [LINK_W:0] sum;
    logic            a_ge_b;

    assign sum    = {1'b0, req.a} + {{LINK_W{1'b0}}, 1'b1};
    assign a_ge_b = (req.a >= req.b);

    always_comb
    begin
        rsp.res  = req.a;
        rsp.flag = 1'b0;
        case (req.op)
            ALU_INC:
            begin
                rsp.res  = a_ge_b ? req.a : sum[LINK_W-1:0];
                rsp.flag = (sum >= {1'b0, req.b});
            end
            ALU_DEC:
            begin
                rsp.flag = (req.a == '0);
                rsp.res  = rsp.flag ? req.a : (req.a - LINK_W'(1));
            end
            ALU_GE:
            begin
                rsp.flag = a_ge_b;
            end
            default:
            begin
                rsp.res  = req.a;
                rsp.flag = 1'b0;
            end
        endcase
    end

endmodule

// File: tb/sv/tb_top.sv
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import tfla_pkg::*;

    // Opcode 3 has no name in the package; the block must reject it
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Cycle budget sized for the worst run (rebuilds at full size, longest gaps and stalls)
    localparam int unsigned CYCLE_LIMIT = 400_000;

    // Cycles left idle after the last response before touching the register
    localparam int unsigned SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [IDX_W-1:0]  granted;
        logic [STAT_W-1:0] status;
        logic [TAG_W-1:0]  tag;
        logic [CNT_W-1:0]  count;
        logic              pool_is_empty;
    } alloc_outcome_t;

    logic clk;
    logic rst_n;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    tfla_cmd_if cmd_ch ();
    tfla_rsp_if rsp_ch ();

    tagged_free_list_allocator DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the pool: link memory, head, tag, counter, capacity.
    // Link entries start unknown; the stimulus only ever builds lists via
    // rebuild and free, so an entry is always written before it is read.
    // ------------------------------------------------------------------
    logic [LINK_W-1:0] link_mem [MAX_BLOCKS];
    logic [LINK_W-1:0] head_ptr;
    logic [TAG_W-1:0]  tag_q;
    logic [CNT_W-1:0]  blocks_free;
    logic [LINK_W-1:0] pool_cap;

    alloc_outcome_t   pending_outcomes [$];
    logic [IDX_W-1:0] held_blocks [$];     // blocks handed out and not yet returned

    int unsigned mismatch_count;
    int unsigned cycle_count;
    int unsigned rsp_hold_cycles;          // long receiver hold-off, counted down below
    bit          cmd_gaps_on;
    bit          rsp_stalls_on;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Watchdog: a hung handshake or a lost response ends up here
    // ------------------------------------------------------------------
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Next state of the pool for one accepted command, and the response
    // it should produce. Capacity saturates at MAX_BLOCKS; zero means the
    // pool was never set up and every real opcode is refused.
    // ------------------------------------------------------------------
    function automatic alloc_outcome_t compute_alloc_outcome(input logic [OP_W-1:0]  op,
                                                             input logic [IDX_W-1:0] idx);
        alloc_outcome_t    res;
        logic [LINK_W-1:0] eff_cap;
        logic [LINK_W-1:0] nxt;
        int                i;
        eff_cap = (pool_cap > LINK_W'(MAX_BLOCKS)) ? LINK_W'(MAX_BLOCKS) : pool_cap;
        res = '0;
        res.status = ST_OK;
        if (op == OP_UNUSED)
            res.status = ST_RANGE;
        else if (eff_cap == '0)
            res.status = ST_NOT_INIT;
        else if (op == OP_ALLOC)
        begin
            if (head_ptr >= NULL_CODE)
                res.status = ST_EMPTY;      // tag left alone on an empty pool
            else
            begin
                res.granted = head_ptr[IDX_W-1:0];
                nxt = link_mem[head_ptr[IDX_W-1:0]];
                // anything past the last block reads as end of list
                head_ptr = (nxt >= NULL_CODE) ? NULL_CODE : nxt;
                tag_q = tag_q + 1'b1;
                if (blocks_free != '0)
                    blocks_free = blocks_free - 1'b1;
            end
        end
        else if (op == OP_FREE)
        begin
            if ({1'b0, idx} >= eff_cap)
                res.status = ST_RANGE;
            else
            begin
                // double free is not caught: the block just goes on again
                link_mem[idx] = head_ptr;
                head_ptr = {1'b0, idx};
                tag_q = tag_q + 1'b1;
                if (blocks_free < CNT_W'(MAX_BLOCKS))
                    blocks_free = blocks_free + 1'b1;
            end
        end
        else
        begin
            for (i = 0; i + 1 < int'(eff_cap); i++)
                link_mem[i] = LINK_W'(i + 1);
            link_mem[eff_cap - 1'b1] = NULL_CODE;
            head_ptr = '0;
            tag_q = '0;
            blocks_free = eff_cap;
        end
        res.tag = tag_q;
        res.count = blocks_free;
        res.pool_is_empty = (head_ptr >= NULL_CODE);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Response checker: every rsp transaction against the oldest outcome
    // ------------------------------------------------------------------
    task automatic flag_mismatch(input string what, input int unsigned want_v,
                                 input int unsigned got_v);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] %s: expected %0d, got %0d", $realtime, what, want_v, got_v);
    endtask

    always @(posedge clk)
    begin
        alloc_outcome_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_outcomes.size() == 0)
                flag_mismatch("response with nothing outstanding", 0, 1);
            else
            begin
                want = pending_outcomes.pop_front();
                if (rsp_ch.granted_index !== want.granted)
                    flag_mismatch("granted_index", want.granted, rsp_ch.granted_index);
                if (rsp_ch.status !== want.status)
                    flag_mismatch("status", want.status, rsp_ch.status);
                if (rsp_ch.head_tag !== want.tag)
                    flag_mismatch("head_tag", want.tag, rsp_ch.head_tag);
                if (rsp_ch.free_count !== want.count)
                    flag_mismatch("free_count", want.count, rsp_ch.free_count);
                if (rsp_ch.pool_empty !== want.pool_is_empty)
                    flag_mismatch("pool_empty", want.pool_is_empty, rsp_ch.pool_empty);
            end
        end
    end

    // ------------------------------------------------------------------
    // Response side: random stalls, mostly short, now and then long, plus
    // the one long hold-off that fills the block up
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rsp_hold_cycles > 0)
            begin
                rsp_ch.ready <= 1'b0;
                rsp_hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (rsp_stalls_on && $urandom_range(0, 99) < 25)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                          : $urandom_range(15, 60);
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Command side. Tasks below are entered and left at a falling edge.
    // ------------------------------------------------------------------
    function automatic int unsigned pick_cmd_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!cmd_gaps_on || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // One cmd transaction; the outcome is worked out the moment it is taken
    task automatic send_command(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                                output alloc_outcome_t outcome);
        int unsigned gap;
        gap = pick_cmd_gap();
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.opcode      <= op;
        cmd_ch.block_index <= idx;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        outcome = compute_alloc_outcome(op, idx);
        pending_outcomes.push_back(outcome);
        @(negedge clk);
    endtask

    // Every command answers once, so an empty queue means the block is idle
    task automatic wait_idle();
        cmd_ch.valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Setup then access phase; the write lands on the access edge
    task automatic write_pool_capacity(input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_POOL_CAPACITY;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        pool_cap = value[LINK_W-1:0];   // upper bits of the bus are ignored
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Straight out of reset the capacity is zero: everything is refused
    task automatic test_not_initialised();
        alloc_outcome_t got;
        send_command(OP_ALLOC,   10'd0,    got);
        send_command(OP_FREE,    10'd0,    got);
        send_command(OP_FREE,    10'd1023, got);
        send_command(OP_REBUILD, 10'd0,    got);
        send_command(OP_UNUSED,  10'd1023, got);
    endtask

    // Three blocks: free before rebuild, range errors, drain to empty,
    // double free handing the same block out twice, counter down to zero
    task automatic test_small_pool();
        alloc_outcome_t got;
        wait_idle();
        write_pool_capacity(32'd3);
        send_command(OP_ALLOC,   10'd0,    got);   // no list yet: empty
        send_command(OP_FREE,    10'd2,    got);   // a free works without a rebuild
        send_command(OP_FREE,    10'd3,    got);   // one past the end
        send_command(OP_REBUILD, 10'd1023, got);
        send_command(OP_ALLOC,   10'd0,    got);
        send_command(OP_ALLOC,   10'd0,    got);
        send_command(OP_ALLOC,   10'd0,    got);
        send_command(OP_ALLOC,   10'd0,    got);   // pool empty
        send_command(OP_FREE,    10'd1,    got);
        send_command(OP_FREE,    10'd1,    got);   // double free
        send_command(OP_ALLOC,   10'd0,    got);
        send_command(OP_ALLOC,   10'd0,    got);   // same block again, counter down to 0
        send_command(OP_UNUSED,  10'd0,    got);
    endtask

    // Capacity above the limit saturates; full-size rebuild and top index
    task automatic test_full_pool();
        alloc_outcome_t got;
        wait_idle();
        write_pool_capacity(32'd2047);
        send_command(OP_REBUILD, 10'd0,    got);
        send_command(OP_FREE,    10'd0,    got);   // counter stays at 1024
        send_command(OP_ALLOC,   10'd0,    got);
        send_command(OP_ALLOC,   10'd0,    got);
        send_command(OP_FREE,    10'd1023, got);
        send_command(OP_ALLOC,   10'd0,    got);
    endtask

    // Receiver holds off for a long stretch while commands keep coming
    task automatic test_backpressure();
        alloc_outcome_t got;
        int             n;
        wait_idle();
        write_pool_capacity(32'd8);
        cmd_gaps_on = 1'b0;
        send_command(OP_REBUILD, 10'd0, got);
        rsp_hold_cycles = 300;
        for (n = 0; n < 16; n++)
            send_command(($urandom_range(0, 1) != 0) ? OP_ALLOC : OP_FREE,
                         IDX_W'($urandom_range(0, 9)), got);
    endtask

    // Mostly alloc and return of blocks actually held, with noise: stray
    // frees (out of range, double), the unused opcode, the odd rebuild
    task automatic test_random_phase(input logic [LINK_W-1:0] cap, input int n_items,
                                     input bit rebuild_first, input bit gaps, input bit stalls,
                                     input bit odd_rebuilds);
        alloc_outcome_t    got;
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  idx;
        logic [LINK_W-1:0] eff_cap;
        int unsigned       pick;
        int unsigned       slot;
        bit                from_held;
        int                n;
        wait_idle();
        write_pool_capacity({21'($urandom_range(0, 2097151)), cap});
        eff_cap = (cap > LINK_W'(MAX_BLOCKS)) ? LINK_W'(MAX_BLOCKS) : cap;
        cmd_gaps_on   = gaps;
        rsp_stalls_on = stalls;
        if (rebuild_first)
        begin
            send_command(OP_REBUILD, IDX_W'($urandom_range(0, MAX_BLOCKS - 1)), got);
            if (got.status == ST_OK)
                held_blocks.delete();
        end
        for (n = 0; n < n_items; n++)
        begin
            pick = $urandom_range(0, 99);
            idx = IDX_W'($urandom_range(0, MAX_BLOCKS - 1));
            from_held = 1'b0;
            slot = 0;
            if (pick < 45)
                op = OP_ALLOC;
            else if (pick < 85)
            begin
                op = OP_FREE;
                if (held_blocks.size() > 0)
                begin
                    slot = $urandom_range(0, held_blocks.size() - 1);
                    idx = held_blocks[slot];
                    from_held = 1'b1;
                end
            end
            else if (pick < 92)
            begin
                op = OP_FREE;
                // half of the stray frees sit right on the capacity boundary
                if ($urandom_range(0, 1) != 0)
                    idx = IDX_W'(eff_cap - LINK_W'($urandom_range(0, 1)));
            end
            else if (pick < 96 || !odd_rebuilds)
                op = OP_UNUSED;
            else
                op = OP_REBUILD;
            send_command(op, idx, got);
            if (got.status == ST_OK)
            begin
                if (op == OP_ALLOC)
                    held_blocks.push_back(got.granted);
                else if (op == OP_FREE && from_held)
                    held_blocks.delete(slot);
                else if (op == OP_REBUILD)
                    held_blocks.delete();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n              = 1'b0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.opcode      = OP_ALLOC;
        cmd_ch.block_index = '0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        mismatch_count     = 0;
        rsp_hold_cycles    = 0;
        cmd_gaps_on        = 1'b1;
        rsp_stalls_on      = 1'b1;
        head_ptr           = NULL_CODE;
        tag_q              = '0;
        blocks_free        = '0;
        pool_cap           = '0;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_not_initialised();
        test_small_pool();
        test_full_pool();
        test_backpressure();

        // long phase with no rebuild after the first, so the tag wraps past 255
        test_random_phase(11'd16,   340, 1'b1, 1'b1, 1'b1, 1'b0);
        test_random_phase(11'd1,     40, 1'b1, 1'b1, 1'b1, 1'b1);
        // back to zero capacity: the list survives but is unusable
        test_random_phase(11'd0,     10, 1'b0, 1'b1, 1'b1, 1'b1);
        // larger capacity on top of the old list, no rebuild first
        test_random_phase(11'd40,    40, 1'b0, 1'b1, 1'b0, 1'b1);
        test_random_phase(11'd1024,  40, 1'b1, 1'b0, 1'b1, 1'b1);
        // stretch with no idling on either side
        test_random_phase(11'd7,     40, 1'b1, 1'b0, 1'b0, 1'b1);

        wait_idle();
        repeat (40) @(negedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: tagged_free_list_allocator.f
hw/rtl/tfla_pkg.sv
hw/rtl/tfla_if.sv
hw/rtl/tfla_link_ram.sv
hw/rtl/tfla_alu.sv
hw/rtl/tagged_free_list_allocator.sv
tb/sv/tb_top.sv
